### rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define PRJ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PRJ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/prj_pkg.sv
// shared widths, constants and types of the point projection pipeline
package prj_pkg;

    localparam int COORD_BITS = 20;
    localparam int COEF_BITS  = 16;
    localparam int FRAC_BITS  = COEF_BITS - 2;

    localparam int CAM_W  = 3 * COORD_BITS;
    localparam int ROW_W  = 3 * COEF_BITS;
    localparam int VIEW_W = 32;
    localparam int FACT_W = 16;
    localparam int CFG_W  = (CAM_W > ROW_W) ? CAM_W : ROW_W;
    localparam int IDX_W  = 3;

    // rotation widths: translated point, after yaw, after pitch-roll
    localparam int T_W    = COORD_BITS + 1;
    localparam int RV_W   = T_W + 4;
    localparam int PROD_W = COEF_BITS + RV_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int RO_W   = SUM_W - FRAC_BITS;

    // projection widths
    localparam int N_W    = RO_W + 1;
    localparam int NUM_W  = N_W + 18;
    localparam int DEN_W  = N_W + 5;
    localparam int DIVD_W = NUM_W + 1;
    localparam int DIVS_W = DEN_W + 1;
    localparam int PIX_W  = 30;
    localparam int PRD_W  = PIX_W + FACT_W + 1;
    localparam int CTR_W  = 14;
    localparam int SCR_W  = 16;

    localparam int OFF_X_Q8    = 461;
    localparam int OFF_Y_Q8    = 614;
    localparam int DEPTH_Q8    = 2560;
    localparam int PITCH_NUM   = 160000;
    localparam int PITCH_DEN   = 23;
    localparam int CENTRE_X_Q4 = 319 * 16;
    localparam int CENTRE_Y_Q4 = 239 * 16;
    localparam int SCR_MAX     = 32767;
    localparam int SCR_MIN     = -32768;

    // |pix| beyond this saturates for any nonzero view factor
    localparam int PIX_LIM = 1 << (PIX_W - 2);
    localparam int Q_SAT   = 1 << (PIX_W - 1);

    // front stages: translate, two rotations of two, offsets, multiply, dividend
    localparam int FRONT_LAT = 8;
    localparam int BACK_LAT  = 3;
    localparam int PIPE_LAT  = FRONT_LAT + DIVD_W + BACK_LAT;

    typedef logic signed [RV_W-1:0] rvec_t;
    typedef logic signed [RO_W-1:0] rout_t;

    typedef struct packed {
        logic neg;
        logic nonneg;
        logic d_zero;
    } lane_ctl_t;

    typedef struct packed {
        logic signed [SCR_W-1:0] coord;
        logic                    clip;
        logic                    bad;
    } scr_out_t;

endpackage

### rtl/prj_rotate.sv
// 3x3 fixed-point rotation: product stage then rounded sum stage
module prj_rotate (
    input  logic                         clk,
    input  logic                         en,
    input  logic [prj_pkg::ROW_W-1:0]    rows [3],
    input  prj_pkg::rvec_t               vin  [3],
    output prj_pkg::rout_t               vout [3]
);
    import prj_pkg::*;

    logic signed [PROD_W-1:0] prod_reg  [3][3];
    logic signed [PROD_W-1:0] prod_next [3][3];
    rout_t                    sum_reg   [3];
    rout_t                    sum_next  [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                prod_next[i][j] = PROD_W'(signed'(rows[i][COEF_BITS*j +: COEF_BITS]))
                                * PROD_W'(vin[j]);
            end
        end
    end

    always_comb
    begin
        logic signed [SUM_W-1:0] acc;
        for (int i = 0; i < 3; i++)
        begin
            acc = SUM_W'(prod_reg[i][0]) + SUM_W'(prod_reg[i][1]) + SUM_W'(prod_reg[i][2])
                + SUM_W'(1 << (FRAC_BITS - 1));
            sum_next[i] = RO_W'(acc >>> FRAC_BITS);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            sum_reg  <= sum_next;
        end
    end

    assign vout = sum_reg;

endmodule

### rtl/prj_divider.sv
// pipelined restoring divider, one quotient bit per stage
module prj_divider (
    input  logic                         clk,
    input  logic                         en,
    input  logic [prj_pkg::DIVD_W-1:0]   dividend,
    input  logic [prj_pkg::DIVS_W-1:0]   divisor,
    output logic [prj_pkg::DIVD_W-1:0]   quotient
);
    import prj_pkg::*;

    // dq holds unused dividend bits on top, quotient bits shift in below
    logic [DIVS_W-1:0] rem_reg  [DIVD_W];
    logic [DIVD_W-1:0] dq_reg   [DIVD_W];
    logic [DIVS_W-1:0] dvs_reg  [DIVD_W];
    logic [DIVS_W-1:0] rem_next [DIVD_W];
    logic [DIVD_W-1:0] dq_next  [DIVD_W];
    logic [DIVS_W-1:0] dvs_next [DIVD_W];

    always_comb
    begin
        logic [DIVS_W-1:0] rem_in;
        logic [DIVD_W-1:0] dq_in;
        logic [DIVS_W-1:0] dvs_in;
        logic [DIVS_W:0]   shifted;
        logic [DIVS_W:0]   trial;
        for (int k = 0; k < DIVD_W; k++)
        begin
            if (k == 0)
            begin
                rem_in = '0;
                dq_in  = dividend;
                dvs_in = divisor;
            end
            else
            begin
                rem_in = rem_reg[k-1];
                dq_in  = dq_reg[k-1];
                dvs_in = dvs_reg[k-1];
            end
            shifted = {rem_in, dq_in[DIVD_W-1]};
            trial   = shifted - {1'b0, dvs_in};
            if (!trial[DIVS_W])
            begin
                rem_next[k] = trial[DIVS_W-1:0];
                dq_next[k]  = {dq_in[DIVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = shifted[DIVS_W-1:0];
                dq_next[k]  = {dq_in[DIVD_W-2:0], 1'b0};
            end
            dvs_next[k] = dvs_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            dq_reg  <= dq_next;
            dvs_reg <= dvs_next;
        end
    end

    assign quotient = dq_reg[DIVD_W-1];

endmodule

### rtl/prj_screen.sv
// quotient to screen coordinate: sign, centre, clamp, view factor, saturate
module prj_screen (
    input  logic                             clk,
    input  logic                             en,
    input  logic [prj_pkg::DIVD_W-1:0]       quotient,
    input  prj_pkg::lane_ctl_t               ctl,
    input  logic signed [prj_pkg::CTR_W-1:0] centre,
    input  logic [prj_pkg::FACT_W-1:0]       factor,
    output prj_pkg::scr_out_t                result
);
    import prj_pkg::*;

    logic signed [PIX_W-1:0] pix_reg,  pix_next;
    lane_ctl_t               ctl1_reg;
    logic signed [PRD_W-1:0] prod_reg, prod_next;
    lane_ctl_t               ctl2_reg;
    scr_out_t                out_reg,  out_next;

    always_comb
    begin
        logic [PIX_W-1:0]        qs;
        logic signed [PIX_W:0]   qv;
        logic signed [PIX_W+1:0] sum;
        if (quotient >= DIVD_W'(Q_SAT))
            qs = PIX_W'(Q_SAT);
        else
            qs = quotient[PIX_W-1:0];
        if (ctl.neg)
            qv = -signed'({1'b0, qs});
        else
            qv = signed'({1'b0, qs});
        sum = (PIX_W+2)'(qv) + (PIX_W+2)'(centre);
        if (sum > (PIX_W+2)'(PIX_LIM))
            pix_next = PIX_W'(PIX_LIM);
        else if (sum < (PIX_W+2)'(-PIX_LIM))
            pix_next = PIX_W'(-PIX_LIM);
        else
            pix_next = PIX_W'(sum);
    end

    assign prod_next = PRD_W'(pix_reg) * PRD_W'(signed'({1'b0, factor}));

    always_comb
    begin
        logic signed [PRD_W-1:0] r;
        r = (prod_reg + PRD_W'(1 << 11)) >>> 12;
        out_next.bad = ctl2_reg.d_zero;
        if (ctl2_reg.d_zero)
        begin
            out_next.clip  = 1'b1;
            out_next.coord = ctl2_reg.nonneg ? SCR_W'(SCR_MAX) : SCR_W'(SCR_MIN);
        end
        else if (r > PRD_W'(SCR_MAX))
        begin
            out_next.clip  = 1'b1;
            out_next.coord = SCR_W'(SCR_MAX);
        end
        else if (r < PRD_W'(SCR_MIN))
        begin
            out_next.clip  = 1'b1;
            out_next.coord = SCR_W'(SCR_MIN);
        end
        else
        begin
            out_next.clip  = 1'b0;
            out_next.coord = SCR_W'(r);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pix_reg  <= pix_next;
            ctl1_reg <= ctl;
            prod_reg <= prod_next;
            ctl2_reg <= ctl1_reg;
            out_reg  <= out_next;
        end
    end

    assign result = out_reg;

endmodule

### rtl/point_rotate_project.sv
// top level: world point to screen coordinate projection pipeline
//
// usage
//   s_* takes one world point per beat: tdata holds x, y, z, each signed
//   q12.8 cm. m_* gives one result beat per point, in order: screen x and
//   y as signed q12.4 pixels, plus the bad depth and clipped flags.
//   cfg_we/cfg_index/cfg_data write one setup register per cycle; write
//   them only while no point is in flight.
// timing
//   one point per cycle sustained while m_tready stays high. stages from
//   accept to m_tvalid: translate (1), yaw rotation (2), pitch-roll
//   rotation (2), offsets (1), pitch multiply (1), dividend setup (1),
//   a 49-stage divider (one quotient bit per stage), then 3 stages of
//   centre, view factor and saturation ending in the output register.
// stall and reset
//   the whole pipeline holds while a result sits in the output register
//   and m_tready is low; s_tready follows the same enable, so nothing is
//   dropped or repeated. reset empties the pipeline and loads identity
//   rotations, zero camera offset and unity view factors.
`include "assert_macros.svh"

module point_rotate_project (
    input  logic                        clk,
    input  logic                        rst_n,
    // setup write port
    input  logic                        cfg_we,
    input  logic [prj_pkg::IDX_W-1:0]   cfg_index,
    input  logic [prj_pkg::CFG_W-1:0]   cfg_data,
    // point_x [19:0], point_y [39:20], point_z [59:40], zero pad
    input  logic [63:0]                 s_tdata,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // screen_x [15:0], screen_y [31:16], bad_depth [32], clipped [33], zero pad
    output logic [39:0]                 m_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready
);
    import prj_pkg::*;

    // setup register indexes
    localparam logic [IDX_W-1:0] CFG_CAMERA = 3'd0;
    localparam logic [IDX_W-1:0] CFG_YAW0   = 3'd1;
    localparam logic [IDX_W-1:0] CFG_YAW1   = 3'd2;
    localparam logic [IDX_W-1:0] CFG_YAW2   = 3'd3;
    localparam logic [IDX_W-1:0] CFG_TILT0  = 3'd4;
    localparam logic [IDX_W-1:0] CFG_TILT1  = 3'd5;
    localparam logic [IDX_W-1:0] CFG_TILT2  = 3'd6;
    localparam logic [IDX_W-1:0] CFG_VIEW   = 3'd7;

    localparam logic [VIEW_W-1:0] VIEW_RESET = VIEW_W'(32'h1000_1000);

    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic pos_x;
        logic pos_y;
        logic d_zero;
    } side_t;

    // setup registers
    logic [CAM_W-1:0]  camera_reg;
    logic [ROW_W-1:0]  yaw_reg  [3];
    logic [ROW_W-1:0]  tilt_reg [3];
    logic [VIEW_W-1:0] view_reg;

    // pipeline control
    logic                pipe_en;
    logic [PIPE_LAT-1:0] valid_reg;

    // translate stage
    rvec_t t_reg  [3];
    rvec_t t_next [3];

    // rotations
    rout_t yaw_out  [3];
    rvec_t a_vec    [3];
    rout_t tilt_out [3];

    // offsets stage
    logic signed [N_W-1:0] nx_reg, ny_reg, d_reg;

    // pitch multiply stage
    logic [NUM_W-1:0] numx_reg, numy_reg;
    logic [DEN_W-1:0] den_reg;
    side_t            side7_reg, side7_next;

    // dividend stage
    logic [DIVD_W-1:0] divdx_reg, divdy_reg;
    logic [DIVS_W-1:0] divs_reg;
    side_t             side8_reg;

    // flags ride along the divider
    side_t side_pipe_reg [DIVD_W];

    logic [DIVD_W-1:0] quot_x, quot_y;
    lane_ctl_t         ctl_x, ctl_y;
    scr_out_t          res_x, res_y;

    // pipeline moves unless a result is waiting on a stalled receiver
    assign pipe_en  = !valid_reg[PIPE_LAT-1] || m_tready;
    assign s_tready = pipe_en;
    assign m_tvalid = valid_reg[PIPE_LAT-1];

    // setup writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            camera_reg  <= '0;
            yaw_reg[0]  <= ROW_W'(1) << FRAC_BITS;
            yaw_reg[1]  <= ROW_W'(1) << (FRAC_BITS + COEF_BITS);
            yaw_reg[2]  <= ROW_W'(1) << (FRAC_BITS + 2 * COEF_BITS);
            tilt_reg[0] <= ROW_W'(1) << FRAC_BITS;
            tilt_reg[1] <= ROW_W'(1) << (FRAC_BITS + COEF_BITS);
            tilt_reg[2] <= ROW_W'(1) << (FRAC_BITS + 2 * COEF_BITS);
            view_reg    <= VIEW_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CAMERA: camera_reg  <= cfg_data[CAM_W-1:0];
                CFG_YAW0:   yaw_reg[0]  <= cfg_data[ROW_W-1:0];
                CFG_YAW1:   yaw_reg[1]  <= cfg_data[ROW_W-1:0];
                CFG_YAW2:   yaw_reg[2]  <= cfg_data[ROW_W-1:0];
                CFG_TILT0:  tilt_reg[0] <= cfg_data[ROW_W-1:0];
                CFG_TILT1:  tilt_reg[1] <= cfg_data[ROW_W-1:0];
                CFG_TILT2:  tilt_reg[2] <= cfg_data[ROW_W-1:0];
                CFG_VIEW:   view_reg    <= cfg_data[VIEW_W-1:0];
                default:    camera_reg  <= camera_reg;
            endcase
        end
    end

    // valid bits shift with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (pipe_en)
            valid_reg <= {valid_reg[PIPE_LAT-2:0], s_tvalid};
    end

    // camera frame: offset minus point, per axis
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            t_next[k] = RV_W'(signed'(camera_reg[COORD_BITS*k +: COORD_BITS]))
                      - RV_W'(signed'(s_tdata[COORD_BITS*k +: COORD_BITS]));
        end
    end

    prj_rotate u_yaw (
        .clk  (clk),
        .en   (pipe_en),
        .rows (yaw_reg),
        .vin  (t_reg),
        .vout (yaw_out)
    );

    // yaw result always fits the narrower rotation input
    always_comb
    begin
        for (int k = 0; k < 3; k++)
            a_vec[k] = signed'(yaw_out[k][RV_W-1:0]);
    end

    prj_rotate u_tilt (
        .clk  (clk),
        .en   (pipe_en),
        .rows (tilt_reg),
        .vin  (a_vec),
        .vout (tilt_out)
    );

    // abs values and quotient signs for the pitch multiply
    always_comb
    begin
        side7_next.neg_x  = nx_reg[N_W-1] ^ d_reg[N_W-1];
        side7_next.neg_y  = ny_reg[N_W-1] ^ d_reg[N_W-1];
        side7_next.pos_x  = !nx_reg[N_W-1];
        side7_next.pos_y  = !ny_reg[N_W-1];
        side7_next.d_zero = (d_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        logic [N_W-1:0] anx, any, ad;
        anx = nx_reg[N_W-1] ? N_W'(-nx_reg) : N_W'(nx_reg);
        any = ny_reg[N_W-1] ? N_W'(-ny_reg) : N_W'(ny_reg);
        ad  = d_reg[N_W-1]  ? N_W'(-d_reg)  : N_W'(d_reg);
        if (pipe_en)
        begin
            t_reg     <= t_next;
            // optical offsets and depth
            nx_reg    <= N_W'(tilt_out[0]) - N_W'(OFF_X_Q8);
            ny_reg    <= -N_W'(tilt_out[1]) - N_W'(OFF_Y_Q8);
            d_reg     <= -N_W'(tilt_out[2]) - N_W'(DEPTH_Q8);
            // pixel pitch as the ratio 160000 / 23
            numx_reg  <= NUM_W'(anx) * NUM_W'(PITCH_NUM);
            numy_reg  <= NUM_W'(any) * NUM_W'(PITCH_NUM);
            den_reg   <= DEN_W'(ad) * DEN_W'(PITCH_DEN);
            side7_reg <= side7_next;
            // round half away: (2n + d) / 2d on magnitudes
            divdx_reg <= {numx_reg, 1'b0} + DIVD_W'(den_reg);
            divdy_reg <= {numy_reg, 1'b0} + DIVD_W'(den_reg);
            divs_reg  <= {den_reg, 1'b0};
            side8_reg <= side7_reg;
            side_pipe_reg[0] <= side8_reg;
            for (int k = 1; k < DIVD_W; k++)
                side_pipe_reg[k] <= side_pipe_reg[k-1];
        end
    end

    prj_divider u_div_x (
        .clk      (clk),
        .en       (pipe_en),
        .dividend (divdx_reg),
        .divisor  (divs_reg),
        .quotient (quot_x)
    );

    prj_divider u_div_y (
        .clk      (clk),
        .en       (pipe_en),
        .dividend (divdy_reg),
        .divisor  (divs_reg),
        .quotient (quot_y)
    );

    assign ctl_x.neg    = side_pipe_reg[DIVD_W-1].neg_x;
    assign ctl_x.nonneg = side_pipe_reg[DIVD_W-1].pos_x;
    assign ctl_x.d_zero = side_pipe_reg[DIVD_W-1].d_zero;
    assign ctl_y.neg    = side_pipe_reg[DIVD_W-1].neg_y;
    assign ctl_y.nonneg = side_pipe_reg[DIVD_W-1].pos_y;
    assign ctl_y.d_zero = side_pipe_reg[DIVD_W-1].d_zero;

    prj_screen u_scr_x (
        .clk      (clk),
        .en       (pipe_en),
        .quotient (quot_x),
        .ctl      (ctl_x),
        .centre   (CTR_W'(CENTRE_X_Q4)),
        .factor   (view_reg[FACT_W-1:0]),
        .result   (res_x)
    );

    prj_screen u_scr_y (
        .clk      (clk),
        .en       (pipe_en),
        .quotient (quot_y),
        .ctl      (ctl_y),
        .centre   (CTR_W'(CENTRE_Y_Q4)),
        .factor   (view_reg[2*FACT_W-1:FACT_W]),
        .result   (res_y)
    );

    assign m_tdata = {6'b0, res_x.clip | res_y.clip, res_x.bad, res_y.coord, res_x.coord};

    // zero depth always reports saturation on both lanes
    `PRJ_ASSERT_IMP(a_bad_clips, m_tvalid && res_x.bad, res_x.clip && res_y.clip,
        "zero depth without clip")
    // both lanes see the same depth flag
    `PRJ_ASSERT_IMP(a_bad_match, m_tvalid, res_x.bad == res_y.bad, "lane depth flags differ")
    // a held pipeline keeps its valid bits
    `PRJ_ASSERT_NXT(a_stall_hold, !pipe_en, $stable(valid_reg), "valid bits moved in stall")

endmodule

### tb/point_rotate_project_tb.sv
// self-checking testbench of the point projection pipeline
`timescale 1ns / 1ps

module point_rotate_project_tb;

    import prj_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 80;
    localparam int HOLD_CYCLES    = 400;
    localparam int RAND_PHASES    = 8;
    localparam int PHASE_ITEMS    = 230;

    // register indexes, in the order of the setup register map
    typedef enum int {
        REG_CAMERA = 0,
        REG_YAW0   = 1,
        REG_YAW1   = 2,
        REG_YAW2   = 3,
        REG_TILT0  = 4,
        REG_TILT1  = 5,
        REG_TILT2  = 6,
        REG_VIEW   = 7
    } reg_idx_e;

    typedef struct {
        logic signed [SCR_W-1:0] sx;
        logic signed [SCR_W-1:0] sy;
        logic                    bad;
        logic                    clip;
    } screen_t;

    typedef struct {
        int      x;
        int      y;
        int      z;
        bit      typed;
        screen_t want;
    } stim_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [IDX_W-1:0]    cfg_index = '0;
    logic [CFG_W-1:0]    cfg_data = '0;
    logic [63:0]         s_tdata = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [39:0]         m_tdata;
    logic                m_tvalid;
    logic                m_tready = 1'b0;

    // local copy of the setup registers
    logic [CAM_W-1:0]    cam_reg;
    logic [ROW_W-1:0]    yaw_reg [3];
    logic [ROW_W-1:0]    tilt_reg [3];
    logic [VIEW_W-1:0]   view_reg;

    screen_t             screen_q [$];
    int                  errors = 0;
    int                  idle_cycles = 0;
    bit                  calm = 1'b0;      // no idling on either side
    bit                  hold_req = 1'b0;  // ask the receiver for one long hold-off
    bit                  ident_rot = 1'b1; // rotations are identity, zero depth reachable

    point_rotate_project u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // round half up, arithmetic shift floors
    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    // division rounded half away from zero
    function automatic longint div_away(longint n, longint d);
        longint unsigned an, ad, q;
        an = (n < 0) ? longint'(-n) : n;
        ad = (d < 0) ? longint'(-d) : d;
        q  = (2 * an + ad) / (2 * ad);
        return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint coef_of(logic [ROW_W-1:0] row, int j);
        logic signed [COEF_BITS-1:0] c;
        c = row[j*COEF_BITS +: COEF_BITS];
        return longint'(c);
    endfunction

    // pinhole projection of one axis plus view factor and saturation
    function automatic longint screen_axis(longint num, longint den, longint centre,
                                           longint factor, inout bit clip);
        longint pix, s;
        if (den == 0)
        begin
            clip = 1'b1;
            return (num >= 0) ? SCR_MAX : SCR_MIN;
        end
        pix = div_away(num * PITCH_NUM, den * PITCH_DEN) + centre;
        if (pix > (longint'(1) <<< 40))
            pix = longint'(1) <<< 40;
        if (pix < -(longint'(1) <<< 40))
            pix = -(longint'(1) <<< 40);
        s = round_shift(pix * factor, 12);
        if (s > SCR_MAX)
        begin
            clip = 1'b1;
            s = SCR_MAX;
        end
        else if (s < SCR_MIN)
        begin
            clip = 1'b1;
            s = SCR_MIN;
        end
        return s;
    endfunction

    function automatic screen_t project_point(logic [COORD_BITS-1:0] px,
                                              logic [COORD_BITS-1:0] py,
                                              logic [COORD_BITS-1:0] pz);
        longint  t [3], a [3], b [3];
        longint  acc, nx, ny, dd;
        logic signed [COORD_BITS-1:0] cf [3], pf [3];
        bit      clip;
        screen_t r;
        pf[0] = px;
        pf[1] = py;
        pf[2] = pz;
        clip = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            cf[i] = cam_reg[i*COORD_BITS +: COORD_BITS];
            t[i] = longint'(cf[i]) - longint'(pf[i]);
        end
        for (int i = 0; i < 3; i++)
        begin
            acc = 0;
            for (int j = 0; j < 3; j++)
                acc += coef_of(yaw_reg[i], j) * t[j];
            a[i] = round_shift(acc, FRAC_BITS);
        end
        for (int i = 0; i < 3; i++)
        begin
            acc = 0;
            for (int j = 0; j < 3; j++)
                acc += coef_of(tilt_reg[i], j) * a[j];
            b[i] = round_shift(acc, FRAC_BITS);
        end
        nx = b[0] - OFF_X_Q8;
        ny = -b[1] - OFF_Y_Q8;
        dd = -b[2] - DEPTH_Q8;
        r.sx = SCR_W'(screen_axis(nx, dd, CENTRE_X_Q4, longint'(view_reg[15:0]), clip));
        r.sy = SCR_W'(screen_axis(ny, dd, CENTRE_Y_Q4, longint'(view_reg[31:16]), clip));
        r.bad = (dd == 0);
        r.clip = clip;
        return r;
    endfunction

    task automatic flag_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // one setup register write, masked to the register width
    // cfg_we stays high; the caller drops it after the last write
    task automatic write_reg(reg_idx_e idx, logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= IDX_W'(idx);
        cfg_data  <= value[CFG_W-1:0];
        @(posedge clk);
        case (idx)
            REG_CAMERA: cam_reg = value[CAM_W-1:0];
            REG_YAW0, REG_YAW1, REG_YAW2: yaw_reg[idx - REG_YAW0] = value[ROW_W-1:0];
            REG_TILT0, REG_TILT1, REG_TILT2: tilt_reg[idx - REG_TILT0] = value[ROW_W-1:0];
            default: view_reg = value[VIEW_W-1:0];
        endcase
    endtask

    function automatic int gap_len();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 96)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // offer one point beat; the expectation is queued at acceptance
    task automatic send_point(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py,
                              logic [COORD_BITS-1:0] pz, bit typed, screen_t want);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, pz, py, px};
        do
            @(posedge clk);
        while (!s_tready);
        screen_q.push_back(typed ? want : project_point(px, py, pz));
        gap = gap_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // sender pause until the pipeline has drained
    task automatic drain();
        s_tvalid <= 1'b0;
        while (screen_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [ROW_W-1:0] rand_row();
        return {16'($urandom), 16'($urandom), 16'($urandom)};
    endfunction

    function automatic logic [COORD_BITS-1:0] small_coord(int span);
        return COORD_BITS'($urandom_range(0, 2 * span) - span);
    endfunction

    // receiver: random back-pressure, one long hold-off on request
    initial
    begin : rx_proc
        int stall;
        logic signed [SCR_W-1:0] gx, gy;
        screen_t w;
        stall = 0;
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_tready <= 1'b1;
                stall = gap_len();
            end
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                gx = m_tdata[15:0];
                gy = m_tdata[31:16];
                if (screen_q.size() == 0)
                begin
                    $display("result beat with nothing expected at %0t", $realtime);
                    errors++;
                end
                else
                begin
                    w = screen_q.pop_front();
                    if (gx !== w.sx)
                        flag_mismatch("screen_x", gx, w.sx);
                    if (gy !== w.sy)
                        flag_mismatch("screen_y", gy, w.sy);
                    if (m_tdata[32] !== w.bad)
                        flag_mismatch("bad_depth", m_tdata[32], w.bad);
                    if (m_tdata[33] !== w.clip)
                        flag_mismatch("clipped", m_tdata[33], w.clip);
                end
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("point_rotate_project_tb NOT OK");
            $finish;
        end
    end

    initial
    begin : main_proc
        stim_row_t rows [$];
        stim_row_t row;
        screen_t   nul;
        int        kind, mode;
        logic [COORD_BITS-1:0] px, py, pz, cz;

        nul = '{sx: 0, sy: 0, bad: 0, clip: 0};
        cam_reg  = '0;
        for (int i = 0; i < 3; i++)
        begin
            yaw_reg[i]  = ROW_W'(1) << (FRAC_BITS + i * COEF_BITS);
            tilt_reg[i] = yaw_reg[i];
        end
        view_reg = 32'h1000_1000;

        // directed points under reset settings
        rows.push_back('{0, 0, 0, 1, '{6357, 5492, 0, 0}});
        // zero divisor, both numerators negative
        rows.push_back('{0, 0, 2560, 1, '{SCR_MIN, SCR_MIN, 1, 1}});
        rows.push_back('{100, -200, 2560, 0, nul});
        rows.push_back('{-5000, -5000, 2560, 0, nul});
        rows.push_back('{524287, 524287, 524287, 0, nul});
        rows.push_back('{-524288, -524288, -524288, 0, nul});
        rows.push_back('{524287, -524288, 0, 0, nul});
        rows.push_back('{-524288, 524287, 524287, 0, nul});
        rows.push_back('{0, 0, -524288, 0, nul});
        rows.push_back('{0, 0, 524287, 0, nul});
        rows.push_back('{1000, 500, -20000, 0, nul});
        rows.push_back('{-1000, -500, -2000, 0, nul});
        rows.push_back('{461, -614, 2561, 0, nul});
        rows.push_back('{0, 0, 2559, 0, nul});
        rows.push_back('{-1, -1, -1, 0, nul});

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            row = rows[i];
            send_point(COORD_BITS'(row.x), COORD_BITS'(row.y), COORD_BITS'(row.z),
                       row.typed, row.want);
        end
        drain();

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            // every register each phase; phase 2 all ones and full-scale coefficients, phase 3 all zeros
            mode = (ph < 4) ? ph : $urandom_range(0, 4);
            ident_rot = 1'b0;
            case (mode)
                0:
                begin
                    ident_rot = 1'b1;
                    write_reg(REG_CAMERA, {4'b0, small_coord(3000), small_coord(3000),
                                           small_coord(3000)});
                    write_reg(REG_YAW0, 48'h0000_0000_4000);
                    write_reg(REG_YAW1, 48'h0000_4000_0000);
                    write_reg(REG_YAW2, 48'h4000_0000_0000);
                    write_reg(REG_TILT0, 48'h0000_0000_4000);
                    write_reg(REG_TILT1, 48'h0000_4000_0000);
                    write_reg(REG_TILT2, 48'h4000_0000_0000);
                    write_reg(REG_VIEW, {16'($urandom_range(0, 16'h3000)),
                                         16'($urandom_range(0, 16'h3000))});
                end
                1, 4:
                begin
                    write_reg(REG_CAMERA, {$urandom, $urandom});
                    write_reg(REG_YAW0, rand_row());
                    write_reg(REG_YAW1, rand_row());
                    write_reg(REG_YAW2, rand_row());
                    write_reg(REG_TILT0, rand_row());
                    write_reg(REG_TILT1, rand_row());
                    write_reg(REG_TILT2, rand_row());
                    write_reg(REG_VIEW, $urandom);
                end
                2:
                begin
                    write_reg(REG_CAMERA, '1);
                    write_reg(REG_YAW0, '1);
                    write_reg(REG_YAW1, 48'h7fff_8000_7fff);
                    write_reg(REG_YAW2, 48'h8000_7fff_8000);
                    write_reg(REG_TILT0, 48'h8000_8000_8000);
                    write_reg(REG_TILT1, 48'h7fff_7fff_7fff);
                    write_reg(REG_TILT2, '1);
                    write_reg(REG_VIEW, 32'hffff_ffff);
                end
                default:
                begin
                    write_reg(REG_CAMERA, '0);
                    write_reg(REG_YAW0, '0);
                    write_reg(REG_YAW1, '0);
                    write_reg(REG_YAW2, '0);
                    write_reg(REG_TILT0, '0);
                    write_reg(REG_TILT1, '0);
                    write_reg(REG_TILT2, '0);
                    write_reg(REG_VIEW, '0);
                end
            endcase
            cfg_we <= 1'b0;
            calm = (ph == 5);
            if (ph == 1)
                hold_req = 1'b1;   // receiver blocks while points keep coming
            cz = cam_reg[2*COORD_BITS +: COORD_BITS];

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                kind = $urandom_range(0, 9);
                px = small_coord(6000);
                py = small_coord(6000);
                pz = cz + COORD_BITS'(2560 + $urandom_range(256, 40000));
                if (kind < 2)
                begin
                    px = COORD_BITS'($urandom);
                    py = COORD_BITS'($urandom);
                    pz = COORD_BITS'($urandom);
                end
                else if (kind == 2 && ident_rot)
                    pz = cz + COORD_BITS'(2560);  // zero divisor
                else if (kind == 3)
                    pz = cz + COORD_BITS'(2560 + $urandom_range(0, 8) - 4);
                send_point(px, py, pz, 1'b0, nul);
            end
            drain();
        end

        if (errors == 0 && screen_q.size() == 0)
            $display("point_rotate_project_tb OK");
        else
            $display("point_rotate_project_tb NOT OK");
        $finish;
    end

endmodule
